FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the record parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while reset is low.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("unconditional check failed");

`endif

FILE: src/ihex_pkg.sv
// Shared types and constants of the Intel HEX record parser.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam logic [9:0]  POS_MAX     = 10'd1023;
  localparam logic [9:0]  MIN_LINE    = 10'd11;
  localparam logic [15:0] LIMIT_RESET = 16'h7AFE;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_COLON  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_HEX   = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
  localparam logic [2:0] ST_CHECKSUM  = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
  } out_word_t;

  // Per-line parse state plus the extended offset kept across lines.
  typedef struct packed {
    logic [9:0]  char_position;
    logic [9:0]  pending_space_run;
    logic [3:0]  high_nibble;
    logic [7:0]  count_field;
    logic [15:0] record_address;
    logic [7:0]  type_field;
    logic [7:0]  running_sum;
    logic [15:0] offset_value_bytes;
    logic [1:0]  error_flags;
    logic [15:0] extended_offset;
  } ihex_state_t;

endpackage

FILE: src/ihex_step.sv
// Combinational next-state and result logic for one input word.
`timescale 1ns / 1ps

module ihex_step (
  input  ihex_pkg::ihex_state_t cur,
  input  ihex_pkg::in_word_t    word,
  input  logic [15:0]           limit,
  output ihex_pkg::ihex_state_t nxt,
  output logic                  res_valid,
  output ihex_pkg::out_word_t   res
);
  import ihex_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic        is_sp_tab;
  logic        is_ws;
  logic        skip;
  logic [10:0] merged_sum;
  logic [9:0]  pos_m;
  logic [1:0]  flags_m;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [7:0]  b;
  logic [8:0]  k;
  logic [8:0]  idx;
  logic [15:0] off0;
  logic [15:0] start_addr;
  logic [15:0] last_addr;
  logic [9:0]  want_len;
  logic [2:0]  line_st;

  assign is_sp_tab  = (word.ch == CH_SPACE) || (word.ch == CH_TAB);
  assign is_ws      = is_sp_tab || (word.ch == CH_CR);
  assign skip       = (cur.char_position == '0) && (cur.pending_space_run == '0) && is_sp_tab;
  assign off0       = word.file_start ? 16'h0000 : cur.extended_offset;
  assign start_addr = off0 + cur.record_address;
  assign last_addr  = start_addr + {8'h00, cur.count_field} + 16'hFFFF;
  assign want_len   = {1'b0, cur.count_field, 1'b0} + MIN_LINE;
  assign merged_sum = {1'b0, cur.char_position} + {1'b0, cur.pending_space_run};

  // Held-back whitespace followed by content joins the line.
  always_comb begin
    pos_m   = cur.char_position;
    flags_m = cur.error_flags;
    if (cur.pending_space_run != '0) begin
      if (cur.char_position == '0) flags_m[0] = 1'b1;
      if (merged_sum > 11'd1) flags_m[1] = 1'b1;
      pos_m = (merged_sum > {1'b0, POS_MAX}) ? POS_MAX : merged_sum[9:0];
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'h0;
    if (word.ch >= 8'h30 && word.ch <= 8'h39) begin
      hex_nib = word.ch[3:0];
    end else if ((word.ch >= 8'h41 && word.ch <= 8'h46) ||
                 (word.ch >= 8'h61 && word.ch <= 8'h66)) begin
      hex_nib = word.ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign b   = {cur.high_nibble, hex_nib};
  assign k   = pos_m[9:1] - 9'd1;
  assign idx = k - 9'd4;

  always_comb begin
    priority if ((cur.char_position == '0) || cur.error_flags[0]) begin
      line_st = ST_NO_COLON;
    end else if ((cur.char_position == POS_MAX) || !cur.char_position[0] ||
                 (cur.char_position < MIN_LINE)) begin
      line_st = ST_BAD_LEN;
    end else if (cur.error_flags[1]) begin
      line_st = ST_BAD_HEX;
    end else if (cur.char_position != want_len) begin
      line_st = ST_BAD_LEN;
    end else if ((cur.type_field != REC_DATA) && (cur.type_field != REC_EOF) &&
                 (cur.type_field != REC_EXT_SEG) && (cur.type_field != REC_EXT_LIN)) begin
      line_st = ST_BAD_TYPE;
    end else if (((cur.type_field == REC_EXT_SEG) || (cur.type_field == REC_EXT_LIN)) &&
                 (cur.count_field != 8'd2)) begin
      line_st = ST_BAD_LEN;
    end else if (cur.running_sum != 8'h00) begin
      line_st = ST_CHECKSUM;
    end else if ((cur.type_field == REC_DATA) && (last_addr > limit)) begin
      line_st = ST_RANGE;
    end else begin
      line_st = ST_OK;
    end
  end

  always_comb begin
    nxt                 = cur;
    nxt.extended_offset = off0;
    res_valid           = 1'b0;
    res.kind            = KIND_DATA;
    res.data_byte       = 8'h00;
    res.address         = 16'h0000;
    res.status          = ST_OK;
    res.record_type     = cur.type_field;
    res.byte_count      = cur.count_field;
    if (word.end_of_line) begin
      res_valid   = 1'b1;
      res.kind    = KIND_STATUS;
      res.address = start_addr;
      res.status  = line_st;
      nxt         = '0;
      nxt.extended_offset = off0;
      if (line_st == ST_OK) begin
        if (cur.type_field == REC_EXT_SEG) begin
          nxt.extended_offset = {cur.offset_value_bytes[11:0], 4'h0};
        end else if (cur.type_field == REC_EXT_LIN) begin
          nxt.extended_offset = 16'h0000;
        end
      end
    end else if (skip) begin
      nxt.extended_offset = off0;
    end else if (is_ws) begin
      if (cur.pending_space_run < POS_MAX) begin
        nxt.pending_space_run = cur.pending_space_run + 10'd1;
      end
    end else begin
      nxt.pending_space_run = '0;
      nxt.error_flags       = flags_m;
      nxt.char_position     = (pos_m < POS_MAX) ? pos_m + 10'd1 : pos_m;
      if (pos_m == '0) begin
        if (word.ch != CH_COLON) nxt.error_flags[0] = 1'b1;
      end else if (!hex_ok) begin
        nxt.error_flags[1] = 1'b1;
      end else if (pos_m[0]) begin
        nxt.high_nibble = hex_nib;
      end else begin
        nxt.running_sum = cur.running_sum + b;
        priority if (k == 9'd0) begin
          nxt.count_field = b;
        end else if (k == 9'd1) begin
          nxt.record_address[15:8] = b;
        end else if (k == 9'd2) begin
          nxt.record_address[7:0] = b;
        end else if (k == 9'd3) begin
          nxt.type_field = b;
        end else begin
          if (idx == 9'd0) nxt.offset_value_bytes[15:8] = b;
          if (idx == 9'd1) nxt.offset_value_bytes[7:0] = b;
          if ((cur.type_field == REC_DATA) && (idx < {1'b0, cur.count_field}) &&
              (flags_m == '0)) begin
            res_valid     = 1'b1;
            res.data_byte = b;
            res.address   = off0 + cur.record_address + {7'h00, idx};
          end
        end
      end
    end
  end

endmodule

FILE: src/intel_hex_record_parser_core.sv
// Top level of the streaming Intel HEX record parser.
//
// The block takes text one character word at a time on the in channel
// (valid/ready). A word with end_of_line set closes the current line; a word
// with file_start set clears the extended address offset first. Each data
// byte of a type 0 record leaves on the out channel as soon as its second
// hex digit arrives, with its address. Every line ends in one status word;
// bytes of a line whose status is not ok are to be discarded downstream.
// The cfg channel writes end_address_limit; it is always ready and must be
// used only while the block is idle.
//
// Flow: a word accepted on in waits in the input register, and the step runs
// from the input register into the result register, which presents its word
// on out. While out does not stall, the block accepts one word per cycle: the
// parse state is updated by one pass of the step logic per word, and the input
// register refills in the same cycle that it drains. When out stalls, the result
// register holds its word and the input register takes one more word, then in_ready drops.
//
// Reset (synchronous, active high) empties both registers, clears the parse state
// and the extended offset, and restores end_address_limit to 31486.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module intel_hex_record_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihex_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output ihex_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import ihex_pkg::*;

  // Input register: one word waiting for the step logic.
  in_word_t    in_q;
  logic        in_q_valid;

  ihex_state_t state;
  ihex_state_t state_next;
  logic [15:0] limit;

  logic        res_valid;
  out_word_t   res;
  logic        advance;

  // The step fires when a word is held and the result register is free or
  // being emptied this cycle.
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign cfg_ready = 1'b1;

  ihex_step u_step (
    .cur       (state),
    .word      (in_q),
    .limit     (limit),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Result register: loads when the step produces a word, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  `ASSERT_ALWAYS(a_reset_clears_out, clk, $past(rst), !out_valid)
  `ASSERT_IMPLIES(a_empty_takes_word, clk, rst, !in_q_valid, in_ready)
  `ASSERT_IMPLIES(a_data_word_ok, clk, rst, out_valid && (out_word.kind == KIND_DATA), out_word.status == ST_OK)
  `ASSERT_IMPLIES(a_status_no_byte, clk, rst, out_valid && (out_word.kind == KIND_STATUS), out_word.data_byte == 8'h00)

endmodule
